// ===== src/amlag_pkg.sv =====
// Shared types and constants for the audio mixer, limiter and gain control block.
// Used by the config interface, the top level and the port checker.
package amlag_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned MIX_W      = 17;
    localparam int unsigned GAIN_W     = 17;
    localparam int unsigned LIMIT_W    = 17;
    localparam int unsigned STEP_MAX   = 6;
    localparam int unsigned STEP_IDX_W = $clog2(STEP_MAX);
    localparam int unsigned PROD_W     = 35;

    // Unity gain in unsigned Q1.16.
    localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

    // Reduction steps 0.4 + 0.1*j, rounded to Q0.16.
    localparam logic [15:0] STEP_TABLE [0:STEP_MAX-1] = '{
        16'd26214, 16'd32768, 16'd39322, 16'd45875, 16'd52429, 16'd58982
    };

    localparam logic [15:0] UPPER_RESET = 16'd32767;
    localparam logic signed [LIMIT_W-1:0] LOWER_RESET = -17'sd32768;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_UPPER_LIMIT = 1'b0;
    localparam t_cfg_idx CFG_LOWER_LIMIT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic                       channel;
    } t_in_item;

    typedef struct packed {
        logic signed [MIX_W-1:0] mixed_sample;
        logic [GAIN_W-1:0]       gain_after;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LIMIT,
        ST_SRCH_MUL,
        ST_SRCH_CMP,
        ST_UPDATE
    } t_state;

endpackage

// ===== src/amlag_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per request.
// Does not import amlag_pkg; the payload type is given by the T_DATA parameter.
interface amlag_stream_if #(
    parameter type T_DATA = logic
) ();
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/amlag_cfg_if.sv =====
// Register write channel: valid/ready, register index and write data.
// Depends on amlag_pkg for the index type and data width.
interface amlag_cfg_if
    import amlag_pkg::*;
();
    logic                valid;
    logic                ready;
    t_cfg_idx            index;
    logic [LIMIT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/audio_mix_limiter_agc_top.sv =====
// Two-input audio mixer with clip limiter and per-channel automatic gain control.
// Depends on amlag_pkg, amlag_stream_if and amlag_cfg_if.
//
// Channels: i_in takes a request of two signed 16-bit samples and a channel
// number. o_out returns one request per input: the scaled, clipped mix and the
// channel's gain after reduction and recovery. i_cfg writes the upper limit
// (index 0) and the lower limit (index 1); it is always ready.
//
// One shared 17x18 multiplier does all the work under a small sequencer: one
// pass scales the sum by the gain, then each reduction step tried takes a
// multiply state and a compare state. A result is loaded after the scale and
// limit states when no limit is reached, and after the step search too when
// one is; at most STEP_COUNT steps are searched. The input is ready again the
// cycle after the result is loaded, so a new item waits for the last result.
//
// The output register holds a finished result while the receiver stalls; the
// next item is still accepted and worked on, and only its final gain update
// waits until the output register is free.
// Reset clears the output valid flag, sets both channel gains to unity and the limits to
// 32767 and -32768.
module audio_mix_limiter_agc_top
    import amlag_pkg::*;
#(
    parameter int unsigned STEP_COUNT = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    amlag_stream_if.sink   i_in,
    amlag_stream_if.source o_out,
    amlag_cfg_if.sink      i_cfg
);

    localparam logic [STEP_IDX_W-1:0] STEP_START = STEP_IDX_W'(STEP_COUNT - 1);

    t_state r_state, n_state;

    logic                          r_ch;
    logic signed [MIX_W-1:0]       r_sum;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [MIX_W-1:0]       r_scaled;
    logic                          r_hi;
    logic [STEP_IDX_W-1:0]         r_step_idx;
    logic [GAIN_W-1:0]             r_gain_new;
    logic signed [MIX_W-1:0]       r_res;
    logic [GAIN_W-1:0]             r_gain [0:1];
    logic [15:0]                   r_upper;
    logic signed [LIMIT_W-1:0]     r_lower;
    t_out_item                     r_out;
    logic                          r_out_valid;

    logic                          w_in_ready;
    logic                          w_in_take;
    logic                          w_mul_en;
    logic                          w_load_out;
    logic signed [MIX_W-1:0]       w_mul_a;
    logic signed [GAIN_W:0]        w_mul_b;
    logic signed [PROD_W-1:0]      w_mul_p;
    logic signed [MIX_W-1:0]       w_prod_hi;
    logic signed [MIX_W:0]         w_cmp_x;
    logic signed [MIX_W:0]         w_upper_x;
    logic signed [MIX_W:0]         w_lower_x;
    logic                          w_reach_hi;
    logic                          w_reach_lo;
    logic                          w_step_ok;
    logic [GAIN_W-1:0]             w_gap;
    logic [12:0]                   w_inc;
    logic [GAIN_W:0]               w_rec;
    logic [GAIN_W-1:0]             w_gain_final;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Shared multiplier: sum times gain, then scaled value times a step.
    always_comb begin
        if (r_state == ST_SCALE) begin
            w_mul_a = r_sum;
            w_mul_b = {1'b0, r_gain[r_ch]};
        end else begin
            w_mul_a = r_scaled;
            w_mul_b = {2'b00, STEP_TABLE[r_step_idx]};
        end
        w_mul_p = w_mul_a * w_mul_b;
    end

    // The products stay within 34 bits, so the floor shift is a bit slice.
    assign w_prod_hi = r_prod[MIX_W+15:16];
    assign w_cmp_x   = {w_prod_hi[MIX_W-1], w_prod_hi};
    assign w_upper_x = {2'b00, r_upper};
    assign w_lower_x = {r_lower[LIMIT_W-1], r_lower};
    assign w_reach_hi = (w_cmp_x >= w_upper_x);
    assign w_reach_lo = (w_cmp_x <= w_lower_x);
    assign w_step_ok  = r_hi ? (w_cmp_x < w_upper_x) : (w_cmp_x > w_lower_x);

    // Recovery adds the rounded-up sixteenth of the distance to unity.
    assign w_gap        = UNITY - r_gain_new;
    assign w_inc        = 13'((w_gap + 17'd15) >> 4);
    assign w_rec        = {1'b0, r_gain_new} + {5'b00000, w_inc};
    assign w_gain_final = (w_rec > {1'b0, UNITY}) ? UNITY : w_rec[GAIN_W-1:0];

    always_comb begin
        w_in_ready = (r_state == ST_IDLE);
        w_in_take  = w_in_ready && i_in.valid;
        w_mul_en   = (r_state == ST_SCALE) || (r_state == ST_SRCH_MUL);
        w_load_out = (r_state == ST_UPDATE) && (!r_out_valid || o_out.ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_state = ST_LIMIT;
            end
            ST_LIMIT: begin
                if (w_reach_hi || w_reach_lo) begin
                    n_state = ST_SRCH_MUL;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_SRCH_MUL: begin
                n_state = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (w_step_ok || (r_step_idx == '0)) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_state = ST_SRCH_MUL;
                end
            end
            ST_UPDATE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_gain[0]   <= UNITY;
            r_gain[1]   <= UNITY;
            r_upper     <= UPPER_RESET;
            r_lower     <= LOWER_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_UPPER_LIMIT: r_upper <= i_cfg.data[15:0];
                    CFG_LOWER_LIMIT: r_lower <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_load_out) begin
                r_gain[r_ch] <= w_gain_final;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_ch  <= i_in.data.channel;
            r_sum <= MIX_W'(i_in.data.sample_a) + MIX_W'(i_in.data.sample_b);
        end
        if (w_mul_en) begin
            r_prod <= w_mul_p;
        end
        if (r_state == ST_LIMIT) begin
            r_scaled   <= w_prod_hi;
            r_hi       <= w_reach_hi;
            r_step_idx <= STEP_START;
            r_gain_new <= r_gain[r_ch];
            if (w_reach_hi) begin
                r_res <= MIX_W'($signed({1'b0, r_upper}));
            end else if (w_reach_lo) begin
                r_res <= r_lower;
            end else begin
                r_res <= w_prod_hi;
            end
        end
        if (r_state == ST_SRCH_CMP) begin
            if (w_step_ok) begin
                r_gain_new <= {1'b0, STEP_TABLE[r_step_idx]};
            end else if (r_step_idx != '0) begin
                r_step_idx <= r_step_idx - 1'b1;
            end
        end
        if (w_load_out) begin
            r_out.mixed_sample <= r_res;
            r_out.gain_after   <= w_gain_final;
        end
    end

endmodule

// ===== src/amlag_checker.sv =====
// Port-level checks for audio_mix_limiter_agc_top, attached by the bind below.
// Depends on amlag_pkg for the result type and the unity gain constant.
module amlag_checker
    import amlag_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while the receiver stalled");

    // An accepted request keeps the block busy for at least the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a request was taken");

    // A new result only appears while the sequencer is working on a request.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a request in progress");

    // The reported gain never exceeds unity.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.gain_after <= UNITY)
        else $error("reported gain above unity");

endmodule

bind audio_mix_limiter_agc_top amlag_checker u_amlag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
